// ===== hdl/cclc_pkg.sv =====
// Shared types and constants for the chunk container layout checker.
package cclc_pkg;

  localparam int HEADER_BYTES_DEF = 12;
  localparam int POS_W            = 48;
  localparam int SIZE_W           = 32;
  localparam int CNT_W            = 17;
  localparam int MAXC_W           = 16;
  localparam int CFG_W            = 48;
  localparam int CFG_IDX_W        = 2;
  localparam int Q_DEPTH          = 2;

  // Sync word, first byte in the lowest lane.
  localparam logic [31:0] MAGIC_WORD = 32'h4B32_5A4C;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_RAW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_MAGIC = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_PAST_END = 3'd3;
  localparam logic [2:0] ST_COUNT    = 3'd4;
  localparam logic [2:0] ST_SMALL    = 3'd5;
  localparam logic [2:0] ST_SUM      = 3'd6;
  localparam logic [2:0] ST_TRAILING = 3'd7;

  localparam logic KIND_CHUNK   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // One byte with its position in the entry, as handed from front to back.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] left;
    logic             last_byte;
  } qitem_t;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  chunk_offset;
    logic [SIZE_W-1:0] raw_size;
    logic [SIZE_W-1:0] packed_size;
    logic [2:0]        status;
    logic [POS_W-1:0]  total_raw;
    logic [POS_W-1:0]  consumed;
    logic [POS_W-1:0]  trailing;
  } result_t;

endpackage

// ===== hdl/cclc_front.sv =====
// Front part: accepts bytes, tracks the byte position and flags the final byte.
module cclc_front
  import cclc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic [POS_W-1:0] entry_size,
  input  logic             q_full,
  output logic             q_push,
  output qitem_t           q_item
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W:0]   diff;
  logic [POS_W-1:0] left;
  logic             last;

  assign diff     = {1'b0, entry_size} - {1'b0, pos_r};
  assign left     = diff[POS_W] ? '0 : diff[POS_W-1:0];
  assign last     = (left <= POS_W'(1));
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.data_byte = in_data_byte;
    q_item.pos       = pos_r;
    q_item.left      = left;
    q_item.last_byte = last;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      pos_nxt = last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== hdl/cclc_queue.sv =====
// Short queue of classified bytes between the front and back parts.
module cclc_queue
  import cclc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t push_item,
  input  logic   pop,
  output qitem_t pop_item,
  output logic   not_empty,
  output logic   full
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  qitem_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_QW'(Q_DEPTH));
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_QW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/cclc_back.sv =====
// Back part: walks the chunk headers and produces chunk records and verdicts.
module cclc_back
  import cclc_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  qitem_t            q_item,
  output logic              q_pop,
  input  logic [POS_W-1:0]  entry_size,
  input  logic [POS_W-1:0]  expected_raw,
  input  logic [MAXC_W-1:0] max_chunks,
  output logic              out_valid,
  input  logic              out_stall,
  output result_t           out_res
);

  localparam int IW = $clog2(HEADER_BYTES);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TAIL,
    PH_ERROR
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              magic_r, magic_nxt;
  logic [SIZE_W-1:0] raw_r, raw_nxt;
  logic [SIZE_W-1:0] packed_r, packed_nxt;
  logic [SIZE_W-1:0] left_pl_r, left_pl_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  raw_sum_r, raw_sum_nxt;
  logic [POS_W-1:0]  hdr_start_r, hdr_start_nxt;
  logic [POS_W-1:0]  hdr_end_r, hdr_end_nxt;
  logic [POS_W-1:0]  avail_r, avail_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           res_r, res_nxt;

  logic              out_free;
  logic              res_hit;
  result_t           res;
  logic              go;
  logic              mag;
  logic [POS_W-1:0]  stop_pos;
  logic [POS_W:0]    trail_diff;

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = q_not_empty && out_free;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    magic_nxt     = magic_r;
    raw_nxt       = raw_r;
    packed_nxt    = packed_r;
    left_pl_nxt   = left_pl_r;
    count_nxt     = count_r;
    raw_sum_nxt   = raw_sum_r;
    hdr_start_nxt = hdr_start_r;
    hdr_end_nxt   = hdr_end_r;
    avail_nxt     = avail_r;
    res_hit       = 1'b0;
    res           = '0;
    go            = 1'b0;
    mag           = magic_r;
    stop_pos      = hdr_start_r;
    trail_diff    = '0;

    unique case (phase_r)
      PH_PAYLOAD: begin
        if (left_pl_r != '0) begin
          left_pl_nxt = left_pl_r - SIZE_W'(1);
        end
        if (left_pl_nxt == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        go = 1'b1;
        if (idx_r == '0) begin
          // A header opens here: the walk's stopping point moves to this byte.
          stop_pos      = q_item.pos;
          hdr_start_nxt = q_item.pos;
          hdr_end_nxt   = q_item.pos + POS_W'(HEADER_BYTES);
          avail_nxt     = q_item.left - POS_W'(HEADER_BYTES);
          mag           = 1'b1;
          if (q_item.left < POS_W'(HEADER_BYTES)) begin
            phase_nxt = PH_TAIL;
            go        = 1'b0;
          end
        end
        if (go) begin
          if (idx_r < IW'(4)) begin
            if (q_item.data_byte != MAGIC_WORD[{idx_r[1:0], 3'b000} +: 8]) begin
              mag = 1'b0;
            end
            magic_nxt = mag;
            if (idx_r == IW'(3) && !mag) begin
              go = 1'b0;
              if (count_r == '0) begin
                phase_nxt  = PH_ERROR;
                res_hit    = 1'b1;
                res.kind   = KIND_VERDICT;
                res.status = ST_NO_MAGIC;
                res.total_raw = raw_sum_r;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
          end else if (idx_r < IW'(8)) begin
            raw_nxt = {q_item.data_byte, raw_r[SIZE_W-1:8]};
          end else if (idx_r < IW'(12)) begin
            packed_nxt = {q_item.data_byte, packed_r[SIZE_W-1:8]};
          end
        end
        if (go) begin
          if (idx_r != IW'(HEADER_BYTES - 1)) begin
            idx_nxt = idx_r + IW'(1);
          end else begin
            idx_nxt = '0;
            res_hit = 1'b1;
            priority if (raw_nxt == '0 || packed_nxt == '0) begin
              phase_nxt     = PH_ERROR;
              res.kind      = KIND_VERDICT;
              res.status    = ST_ZERO;
              res.total_raw = raw_sum_r;
            end else if (POS_W'(packed_nxt) > avail_r) begin
              phase_nxt     = PH_ERROR;
              res.kind      = KIND_VERDICT;
              res.status    = ST_PAST_END;
              res.total_raw = raw_sum_r;
            end else if (count_r >= CNT_W'(max_chunks)) begin
              phase_nxt     = PH_ERROR;
              res.kind      = KIND_VERDICT;
              res.status    = ST_COUNT;
              res.total_raw = raw_sum_r;
            end else begin
              count_nxt        = count_r + CNT_W'(1);
              raw_sum_nxt      = raw_sum_r + POS_W'(raw_nxt);
              hdr_start_nxt    = hdr_end_r + POS_W'(packed_nxt);
              left_pl_nxt      = packed_nxt;
              phase_nxt        = PH_PAYLOAD;
              res.kind         = KIND_CHUNK;
              res.chunk_offset = hdr_start_r;
              res.raw_size     = raw_nxt;
              res.packed_size  = packed_nxt;
              res.status       = ST_OK;
              res.total_raw    = raw_sum_nxt;
            end
          end
        end
      end
      PH_TAIL, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (q_item.last_byte) begin
      if (!res_hit && phase_nxt != PH_ERROR) begin
        // The walk ends at the next header position, clamped to the entry.
        trail_diff    = {1'b0, entry_size} - {1'b0, stop_pos};
        res_hit       = 1'b1;
        res.kind      = KIND_VERDICT;
        res.total_raw = raw_sum_r;
        if (trail_diff[POS_W]) begin
          res.consumed = entry_size;
          res.trailing = '0;
        end else begin
          res.consumed = stop_pos;
          res.trailing = trail_diff[POS_W-1:0];
        end
        priority if (count_r == '0) begin
          res.status = ST_SMALL;
        end else if (raw_sum_r != expected_raw) begin
          res.status = ST_SUM;
        end else if (res.trailing != '0) begin
          res.status = ST_TRAILING;
        end else begin
          res.status = ST_OK;
        end
      end
      phase_nxt     = PH_HEADER;
      idx_nxt       = '0;
      magic_nxt     = 1'b1;
      raw_nxt       = '0;
      packed_nxt    = '0;
      left_pl_nxt   = '0;
      count_nxt     = '0;
      raw_sum_nxt   = '0;
      hdr_start_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    if (q_pop && res_hit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= '0;
      magic_r     <= 1'b1;
      raw_r       <= '0;
      packed_r    <= '0;
      left_pl_r   <= '0;
      count_r     <= '0;
      raw_sum_r   <= '0;
      hdr_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r     <= phase_nxt;
        idx_r       <= idx_nxt;
        magic_r     <= magic_nxt;
        raw_r       <= raw_nxt;
        packed_r    <= packed_nxt;
        left_pl_r   <= left_pl_nxt;
        count_r     <= count_nxt;
        raw_sum_r   <= raw_sum_nxt;
        hdr_start_r <= hdr_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (q_pop) begin
      hdr_end_r <= hdr_end_nxt;
      avail_r   <= avail_nxt;
    end
  end

endmodule

// ===== hdl/chunk_container_layout_checker_unit.sv =====
// Top level of the chunk container layout checker: registers, front, queue and back.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid, in_stall, in_data_byte    | in
//   result  | out_valid, out_stall, out_* fields  | out
//   config  | cfg_wr_en, cfg_index, cfg_wdata     | in
//
// One byte is taken every cycle while in_stall is low; each byte passes the queue and its result is registered.
// The header walk in the back part carries its state from byte to byte.
// Reset is synchronous; no clearing pass is needed, the block is ready at once.
// A stalled result holds the back part; the two-entry queue then fills and
// in_stall rises.
module chunk_container_layout_checker_unit
  import cclc_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [POS_W-1:0]     out_chunk_offset,
  output logic [SIZE_W-1:0]    out_raw_size,
  output logic [SIZE_W-1:0]    out_packed_size,
  output logic [2:0]           out_status,
  output logic [POS_W-1:0]     out_total_raw,
  output logic [POS_W-1:0]     out_consumed,
  output logic [POS_W-1:0]     out_trailing
);

  logic [POS_W-1:0]  entry_size_r;
  logic [POS_W-1:0]  expected_raw_r;
  logic [MAXC_W-1:0] max_chunks_r;

  logic    q_push, q_pop, q_full, q_not_empty;
  qitem_t  push_item, pop_item;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_size_r   <= POS_W'(1);
      expected_raw_r <= '0;
      max_chunks_r   <= MAXC_W'(1024);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENTRY_SIZE:   entry_size_r   <= cfg_wdata[POS_W-1:0];
        CFG_EXPECTED_RAW: expected_raw_r <= cfg_wdata[POS_W-1:0];
        CFG_MAX_CHUNKS:   max_chunks_r   <= cfg_wdata[MAXC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cclc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .entry_size   (entry_size_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  cclc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  cclc_back #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_not_empty  (q_not_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .entry_size   (entry_size_r),
    .expected_raw (expected_raw_r),
    .max_chunks   (max_chunks_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_kind         = res.kind;
  assign out_chunk_offset = res.chunk_offset;
  assign out_raw_size     = res.raw_size;
  assign out_packed_size  = res.packed_size;
  assign out_status       = res.status;
  assign out_total_raw    = res.total_raw;
  assign out_consumed     = res.consumed;
  assign out_trailing     = res.trailing;

endmodule
